@@ sv/vdm_pkg.sv @@
// ----------------------------------------------------------------------------
// vdm_pkg
// shared types and constants for the vector distance metric unit
// ----------------------------------------------------------------------------
package vdm_pkg;

  localparam int ElemBits = 16;
  localparam int FracBits = 12;
  localparam int AccBits  = 48;
  localparam int AbsBits  = 32;
  localparam int DistBits = 44;
  localparam int SqrtBits = 48;

  typedef enum logic [2:0] {
    MetricL2Sq  = 3'd0,
    MetricL2    = 3'd1,
    MetricCos   = 3'd2,
    MetricNegIp = 3'd3,
    MetricL1    = 3'd4
  } metric_e;

  typedef struct packed {
    logic signed [ElemBits-1:0] a_elem;
    logic signed [ElemBits-1:0] b_elem;
    logic                       last;
  } in_word_t;

  typedef struct packed {
    logic signed [DistBits-1:0] distance;
    logic                       not_a_number;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSqrt,
    StDiv,
    StDone,
    StOut
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic acc_en;
    logic fin_start;
    logic mul_go;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sqrt;
    logic need_div;
    logic step_last;
  } sts_t;

endpackage

@@ sv/vdm_ctrl.sv @@
// ----------------------------------------------------------------------------
// vdm_ctrl
// sequencer for the per-vector finish: multiply, root, divide, output
// ----------------------------------------------------------------------------
module vdm_ctrl import vdm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_last_i) state_d = StMul;
      end
      StMul: begin
        if (sts_i.need_sqrt) state_d = StSqrt;
        else state_d = StDone;
      end
      StSqrt: begin
        if (sts_i.step_last) state_d = sts_i.need_div ? StDiv : StDone;
      end
      StDiv: begin
        if (sts_i.step_last) state_d = StDone;
      end
      StDone: state_d = StOut;
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o       = 1'b1;
        cmd_o.acc_en     = in_valid_i;
        cmd_o.fin_start  = in_valid_i && in_last_i;
      end
      StMul: begin
        cmd_o.mul_go     = 1'b1;
        cmd_o.sqrt_start = sts_i.need_sqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.div_start = sts_i.step_last && sts_i.need_div;
      end
      StDiv: cmd_o.div_step = 1'b1;
      StDone: cmd_o.finish = 1'b1;
      StOut: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ sv/vdm_datapath.sv @@
// ----------------------------------------------------------------------------
// vdm_datapath
// accumulators, shared bit-serial square root and restoring divider
// ----------------------------------------------------------------------------
module vdm_datapath import vdm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  metric_e   metric_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_word_t out_word_o
);

  localparam logic signed [AccBits-1:0] AccMax = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] AccMin = {1'b1, {(AccBits-1){1'b0}}};
  localparam int DivSteps = 2 * FracBits;
  localparam logic [AccBits-1:0] OneOut = AccBits'(1) << DivSteps;
  localparam logic signed [AccBits+1:0] DistHigh = (AccBits+2)'(1) << 42;
  localparam logic signed [AccBits+1:0] DistLow  = -((AccBits+2)'(1) << 40);

  logic signed [AccBits-1:0] dot_q;
  logic [AccBits-1:0] na_q, nb_q, sq_q;
  logic [AbsBits-1:0] ad_q;
  logic [2:0] met_q;

  // per pair arithmetic
  logic signed [ElemBits:0] diff;
  logic [ElemBits:0] adiff;
  logic [ElemBits-1:0] ua, ub;
  logic [2*ElemBits-1:0] ua_sq, ub_sq;
  logic [2*ElemBits+1:0] ad_sq;
  logic signed [2*ElemBits-1:0] prod;
  logic signed [AccBits:0] dsum;
  logic [AccBits:0] na_s, nb_s, sq_s;
  logic [AbsBits:0] ad_s;
  logic [AccBits-1:0] na_n, nb_n, sq_n;
  logic signed [AccBits-1:0] dot_n;
  logic [AbsBits-1:0] ad_n;

  always_comb begin
    diff  = {in_word_i.a_elem[ElemBits-1], in_word_i.a_elem}
            - {in_word_i.b_elem[ElemBits-1], in_word_i.b_elem};
    adiff = diff[ElemBits] ? (ElemBits+1)'(-diff) : diff;
    ua    = in_word_i.a_elem[ElemBits-1] ? ElemBits'(-in_word_i.a_elem) : in_word_i.a_elem;
    ub    = in_word_i.b_elem[ElemBits-1] ? ElemBits'(-in_word_i.b_elem) : in_word_i.b_elem;
    ua_sq = ua * ua;
    ub_sq = ub * ub;
    ad_sq = adiff * adiff;
    prod  = in_word_i.a_elem * in_word_i.b_elem;
    dsum  = {dot_q[AccBits-1], dot_q} + (AccBits+1)'(prod);
    if (dsum > (AccBits+1)'(AccMax)) dot_n = AccMax;
    else if (dsum < (AccBits+1)'(AccMin)) dot_n = AccMin;
    else dot_n = dsum[AccBits-1:0];
    na_s = {1'b0, na_q} + (AccBits+1)'(ua_sq);
    nb_s = {1'b0, nb_q} + (AccBits+1)'(ub_sq);
    sq_s = {1'b0, sq_q} + (AccBits+1)'(ad_sq);
    ad_s = {1'b0, ad_q} + (AbsBits+1)'(adiff);
    na_n = (na_s > (AccBits+1)'(AccMax)) ? AccMax : na_s[AccBits-1:0];
    nb_n = (nb_s > (AccBits+1)'(AccMax)) ? AccMax : nb_s[AccBits-1:0];
    sq_n = (sq_s > (AccBits+1)'(AccMax)) ? AccMax : sq_s[AccBits-1:0];
    ad_n = ad_s[AbsBits] ? '1 : ad_s[AbsBits-1:0];
  end

  // frozen copies for the finish
  logic signed [AccBits-1:0] fdot_q;
  logic [AccBits-1:0] fna_q, fnb_q, fsq_q;
  logic [AbsBits-1:0] fad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sq_q  <= '0;
      ad_q  <= '0;
    end else if (cmd_i.fin_start) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      sq_q  <= '0;
      ad_q  <= '0;
    end else if (cmd_i.acc_en) begin
      dot_q <= dot_n;
      na_q  <= na_n;
      nb_q  <= nb_n;
      sq_q  <= sq_n;
      ad_q  <= ad_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_start) begin
      fdot_q <= dot_n;
      fna_q  <= na_n;
      fnb_q  <= nb_n;
      fsq_q  <= sq_n;
      fad_q  <= ad_n;
      met_q  <= metric_i;
    end
  end

  // norm product, 48x48 cut into four 24x24 partials, used in the mul state
  logic [95:0] norm_prod;
  logic [47:0] pp00, pp01, pp10, pp11;
  always_comb begin
    pp00 = fna_q[23:0]  * fnb_q[23:0];
    pp01 = fna_q[23:0]  * fnb_q[47:24];
    pp10 = fna_q[47:24] * fnb_q[23:0];
    pp11 = fna_q[47:24] * fnb_q[47:24];
  end
  assign norm_prod = {pp11, pp00} + ({48'd0, pp01} << 24) + ({48'd0, pp10} << 24);

  logic is_zero_norm;
  assign is_zero_norm = (fna_q == '0) || (fnb_q == '0);
  assign sts_o.need_sqrt = (met_q == MetricL2) || ((met_q == MetricCos) && !is_zero_norm);
  assign sts_o.need_div  = (met_q == MetricCos) && !is_zero_norm;

  // bit-serial floor square root, one result bit per cycle (restoring form)
  logic [95:0] rad_q;
  logic [SqrtBits+1:0] srem_q;
  logic [SqrtBits-1:0] root_q;
  logic [5:0] cnt_q;
  logic [SqrtBits+1:0] strial;
  logic [SqrtBits+1:0] srem_sh;
  always_comb begin
    srem_sh = {srem_q[SqrtBits-1:0], rad_q[95:94]};
    strial  = srem_sh - {root_q, 2'b01};
  end

  // divider
  logic [AccBits-1:0] drem_q, den_q;
  logic [AccBits-1:0] q_q;
  logic [AccBits:0] dsh;
  logic sat_one_q;
  assign dsh = {drem_q, 1'b0};

  assign sts_o.step_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= (met_q == MetricL2) ? ({48'd0, fsq_q} << DivSteps) : norm_prod;
      srem_q <= '0;
      root_q <= '0;
      cnt_q  <= 6'(SqrtBits - 1);
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (!strial[SqrtBits+1]) begin
        srem_q <= strial;
        root_q <= {root_q[SqrtBits-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh;
        root_q <= {root_q[SqrtBits-2:0], 1'b0};
      end
      if (cmd_i.div_start) begin
        cnt_q <= 6'(DivSteps - 1);
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  // final root including this step's bit, for div_start
  logic [SqrtBits-1:0] root_fin;
  assign root_fin = {root_q[SqrtBits-2:0], !strial[SqrtBits+1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      den_q     <= root_fin;
      drem_q    <= fdot_q[AccBits-1] ? AccBits'(-fdot_q) : fdot_q;
      q_q       <= '0;
      sat_one_q <= ((fdot_q[AccBits-1] ? AccBits'(-fdot_q) : fdot_q) >= root_fin);
    end else if (cmd_i.div_step) begin
      if (dsh >= {1'b0, den_q}) begin
        drem_q <= AccBits'(dsh - {1'b0, den_q});
        q_q    <= {q_q[AccBits-2:0], 1'b1};
      end else begin
        drem_q <= dsh[AccBits-1:0];
        q_q    <= {q_q[AccBits-2:0], 1'b0};
      end
    end
  end

  // result
  logic signed [AccBits+1:0] dist_v;
  logic nan;
  logic [AccBits-1:0] qv;
  always_comb begin
    nan    = 1'b0;
    dist_v = '0;
    qv     = sat_one_q ? OneOut : q_q;
    case (met_q)
      MetricL2Sq:  dist_v = (AccBits+2)'(fsq_q);
      MetricL2:    dist_v = (AccBits+2)'(root_q);
      MetricCos: begin
        if (is_zero_norm) nan = 1'b1;
        else if (fdot_q[AccBits-1]) dist_v = (AccBits+2)'(OneOut) + (AccBits+2)'(qv);
        else dist_v = (AccBits+2)'(OneOut) - (AccBits+2)'(qv);
      end
      MetricNegIp: dist_v = -{{2{fdot_q[AccBits-1]}}, fdot_q};
      MetricL1:    dist_v = (AccBits+2)'(fad_q) << FracBits;
      default:     nan = 1'b1;
    endcase
    if (dist_v > DistHigh) dist_v = DistHigh;
    if (dist_v < DistLow) dist_v = DistLow;
    if (nan) dist_v = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_o.distance     <= dist_v[DistBits-1:0];
      out_word_o.not_a_number <= nan;
    end
  end

endmodule

@@ sv/vector_distance_metric_unit.sv @@
// ----------------------------------------------------------------------------
// vector_distance_metric_unit
// streaming distance between two fixed-point vectors
// ----------------------------------------------------------------------------
// usage:
//  - input channel carries one element pair per word (a_elem, b_elem, last);
//    words without last are taken one per cycle and only update the sums
//  - a word with last starts the finish; the block takes no word until its
//    result word has been taken on the output channel
//  - finish after the last word: l2 squared, inner product, l1 and unknown
//    codes need no iterative step; l2 runs the shared bit-serial root;
//    cosine runs that root and then the restoring divide
//  - metric register at address 0 over the apb port; the user must keep it
//    written only while idle, the block itself does not enforce this
//  - reset clears the sums, the metric and all handshake state
//  - a stalled output holds its word; no input is taken during the stall
// ----------------------------------------------------------------------------
module vector_distance_metric_unit import vdm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  metric_e metric_q;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = {29'd0, metric_q};

  // single register, paddr only wide enough to tell it from nothing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= MetricL2Sq;
    end else if (psel && penable && pwrite && !paddr) begin
      metric_q <= metric_e'(pwdata[2:0]);
    end
  end

  vdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_word_i.last),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vdm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .metric_i   (metric_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

  // no input while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o)
    else $error("input taken during result");

  // result word holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed under stall");

  // a last word always leads away from idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_word_i.last |=> !in_ready_o)
    else $error("last word did not start finish");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// random and directed vectors for the distance unit, scored against a
// behavioral model of the five running sums and the metric finish
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import vdm_pkg::*;

  localparam logic [47:0] AccPosMax = 48'h7FFF_FFFF_FFFF;
  localparam longint      LimitCycles = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_word_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic        paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  vector_distance_metric_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // model state
  logic [2:0]          cur_metric;
  logic signed [47:0]  dot_acc;
  logic [47:0]         norm_a_acc, norm_b_acc, sq_diff_acc;
  logic [31:0]         abs_diff_acc;

  in_word_t  pending_words[$];
  out_word_t expected_dist[$];
  int        fail_count;
  longint    cycle_count;

  // floor square root of a value below 2^96
  function automatic logic [47:0] floor_sqrt(logic [95:0] v);
    logic [47:0] r;
    logic [47:0] t;
    r = '0;
    for (int bit_i = 47; bit_i >= 0; bit_i--) begin
      t = r | (48'd1 << bit_i);
      if (96'(t) * 96'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [47:0] sat_add(logic [47:0] acc, logic [47:0] add,
                                          logic [47:0] lim);
    logic [48:0] s;
    s = {1'b0, acc} + {1'b0, add};
    return (s > {1'b0, lim}) ? lim : s[47:0];
  endfunction

  // fold one pair into the sums; returns 1 and the distance on a last word
  function automatic bit accumulate_pair(in_word_t w, output out_word_t res);
    longint a, b, d, ad, s, dist_v, mag, q, rem;
    logic [47:0] den;
    bit nan;
    a = w.a_elem;
    b = w.b_elem;
    d = a - b;
    ad = d < 0 ? -d : d;
    s = longint'(dot_acc) + a * b;
    if (s > longint'(AccPosMax)) s = longint'(AccPosMax);
    if (s < -longint'(AccPosMax) - 1) s = -longint'(AccPosMax) - 1;
    dot_acc = s;
    norm_a_acc = sat_add(norm_a_acc, 48'(a * a), AccPosMax);
    norm_b_acc = sat_add(norm_b_acc, 48'(b * b), AccPosMax);
    sq_diff_acc = sat_add(sq_diff_acc, 48'(ad * ad), AccPosMax);
    abs_diff_acc = 32'(sat_add({16'd0, abs_diff_acc}, 48'(ad), 48'hFFFF_FFFF));
    res = '0;
    if (!w.last) return 0;
    dist_v = 0;
    nan = 0;
    case (cur_metric)
      MetricL2Sq:  dist_v = longint'(sq_diff_acc);
      MetricL2:    dist_v = longint'(floor_sqrt(96'(sq_diff_acc) << (2 * FracBits)));
      MetricCos: begin
        if (norm_a_acc == 0 || norm_b_acc == 0) begin
          nan = 1;
        end else begin
          den = floor_sqrt(96'(norm_a_acc) * 96'(norm_b_acc));
          mag = dot_acc < 0 ? -longint'(dot_acc) : longint'(dot_acc);
          q = 0;
          if (mag >= longint'(den)) begin
            q = longint'(1) << (2 * FracBits);
          end else begin
            rem = mag;
            for (int i = 0; i < 2 * FracBits; i++) begin
              rem = rem << 1;
              q = q << 1;
              if (rem >= longint'(den)) begin
                rem -= longint'(den);
                q |= 1;
              end
            end
          end
          dist_v = (longint'(1) << (2 * FracBits)) - (dot_acc < 0 ? -q : q);
        end
      end
      MetricNegIp: dist_v = -longint'(dot_acc);
      MetricL1:    dist_v = longint'(abs_diff_acc) << FracBits;
      default:     nan = 1;
    endcase
    if (dist_v > (longint'(1) << 42)) dist_v = longint'(1) << 42;
    if (dist_v < -(longint'(1) << 40)) dist_v = -(longint'(1) << 40);
    if (nan) dist_v = 0;
    res.distance = dist_v[DistBits-1:0];
    res.not_a_number = nan;
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    sq_diff_acc = '0;
    abs_diff_acc = '0;
    return 1;
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("** vector_distance_metric_unit: FAILED **");
      $finish;
    end
  end

  // sender: bursts of words separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i && in_ready_o) begin
        out_word_t res;
        if (accumulate_pair(in_word_i, res)) expected_dist.push_back(res);
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid_i <= 1'b1;
        in_word_i  <= pending_words.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern mode changes now and then
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 1) == 0);
        2:       out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= (cycle_count[2:0] != 3'd0);
      endcase
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_dist.size() == 0) begin
        $error("result word with nothing expected: distance %0d",
               $signed(out_word_o.distance));
        fail_count++;
      end else begin
        out_word_t exp_w;
        exp_w = expected_dist.pop_front();
        if (out_word_o.distance !== exp_w.distance) begin
          $error("distance expected %0d actual %0d",
                 $signed(exp_w.distance), $signed(out_word_o.distance));
          fail_count++;
        end
        if (out_word_o.not_a_number !== exp_w.not_a_number) begin
          $error("not_a_number expected %0b actual %0b",
                 exp_w.not_a_number, out_word_o.not_a_number);
          fail_count++;
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // queue one vector pair of the given length
  task automatic queue_vector(int len, bit zero_a, bit zero_b);
    in_word_t w;
    for (int i = 0; i < len; i++) begin
      w.a_elem = zero_a ? 16'sd0 : rand_elem();
      w.b_elem = zero_b ? 16'sd0 : rand_elem();
      w.last   = (i == len - 1);
      pending_words.push_back(w);
    end
  endtask

  task automatic queue_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst);
    in_word_t w;
    w.a_elem = a;
    w.b_elem = b;
    w.last   = lst;
    pending_words.push_back(w);
  endtask

  // register write, setup then access cycle
  task automatic write_metric(logic [2:0] code);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 1'b0;
    pwdata  <= {29'd0, code};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_metric = code;
  endtask

  // let the queued words drain and every result arrive
  task automatic drain_all();
    while (pending_words.size() > 0 || in_valid_i || expected_dist.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  logic [2:0] phase_codes[$];

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 1'b0;
    pwdata = '0;
    cycle_count = 0;
    fail_count = 0;
    cur_metric = MetricL2Sq;
    dot_acc = '0;
    norm_a_acc = '0;
    norm_b_acc = '0;
    sq_diff_acc = '0;
    abs_diff_acc = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes under the reset metric, then one per code
    queue_pair(16'sh7FFF, 16'sh8000, 1'b0);
    queue_pair(16'sh8000, 16'sh7FFF, 1'b1);
    queue_pair(16'sh8000, 16'sh8000, 1'b1);
    drain_all();
    for (int m = 1; m < 8; m++) begin
      write_metric(3'(m));
      queue_pair(16'sh7FFF, 16'sh7FFF, 1'b1);          // identical vectors
      queue_pair(16'sh8000, 16'sh7FFF, 1'b1);          // opposite vectors
      queue_pair(16'sd0, 16'sh1000, 1'b1);             // zero norm
      queue_pair(16'sd5, -16'sd3, 1'b0);
      queue_pair(-16'sd7, 16'sd2, 1'b1);
      drain_all();
    end

    // random phases across codes 0 to 5 and 7, l2 squared and l1 first and last
    phase_codes = '{MetricL2Sq, MetricL1, MetricCos, MetricL2, MetricNegIp,
                    3'd5, MetricCos, 3'd7, MetricL2Sq, MetricL1};
    foreach (phase_codes[p]) begin
      write_metric(phase_codes[p]);
      for (int v = 0; v < 30; v++) begin
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40)
                                           : $urandom_range(1, 6);
        queue_vector(len, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
      end
      drain_all();
    end

    if (fail_count == 0) begin
      $display("** vector_distance_metric_unit: PASSED **");
    end else begin
      $display("** vector_distance_metric_unit: FAILED **");
    end
    $finish;
  end

endmodule
